>>> rtl/core/rci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_pkg
// Shared widths and transaction types for the ray and circle intersection
// pipeline.
// ----------------------------------------------------------------------------
package rci_pkg;

    // field formats
    localparam int COORD_BITS = 24;
    localparam int DIR_BITS   = 16;
    localparam int DIR_FRAC   = 14;
    localparam int RAD_BITS   = COORD_BITS - 1;

    // projection path widths
    localparam int V_W    = COORD_BITS + 1;
    localparam int DOTP_W = V_W + DIR_BITS;
    localparam int DOT_W  = DOTP_W + 1;
    localparam int T_W    = DOT_W - DIR_FRAC;
    localparam int MT_W   = T_W + DIR_BITS;
    localparam int P_W    = MT_W - DIR_FRAC + 1;
    localparam int E_W    = P_W + 1;

    // distance test widths
    localparam int MAG_W = (E_W > 31) ? 31 : E_W;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int Q_W   = SQ_W + 1;
    localparam int FAR_W = 64;
    localparam logic [FAR_W-1:0] FAR_LIMIT = 64'h0000_0000_8000_0000;

    // square root chain widths
    localparam int ROOT_W = RAD_BITS;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int CMP_W  = (Q_W > RAD_W) ? Q_W : RAD_W;
    localparam int REM_W  = ROOT_W + 3;

    // entry point widths
    localparam int T1_W = ((T_W > ROOT_W + 1) ? T_W : ROOT_W + 1) + 1;
    localparam int M1_W = T1_W + DIR_BITS;
    localparam int P1_W = ((M1_W - DIR_FRAC > COORD_BITS) ? M1_W - DIR_FRAC : COORD_BITS) + 1;

    // request transaction
    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [DIR_BITS-1:0]   dir_x;
        logic signed [DIR_BITS-1:0]   dir_y;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic        [RAD_BITS-1:0]   radius;
    } t_ray_in;

    // result transaction
    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] entry_distance;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } t_ray_out;

    // values riding along the square root chain
    typedef struct packed {
        logic                         vld;
        logic                         hit;
        logic signed [T_W-1:0]        t;
        logic signed [COORD_BITS-1:0] ox;
        logic signed [COORD_BITS-1:0] oy;
        logic signed [DIR_BITS-1:0]   dx;
        logic signed [DIR_BITS-1:0]   dy;
    } t_side;

    // square root working set of one cell
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_lane;

endpackage

>>> rtl/core/rci_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_sqrt_cell
// One digit of a restoring integer square root: shifts in two radicand bits,
// tries the next root bit and passes the working set to the next cell.
// ----------------------------------------------------------------------------
module rci_sqrt_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rci_pkg::t_side   i_side,
    input  rci_pkg::t_lane   i_lane,
    output rci_pkg::t_side   o_side,
    output rci_pkg::t_lane   o_lane
);

    localparam int RADW  = rci_pkg::RAD_W;
    localparam int REMW  = rci_pkg::REM_W;
    localparam int ROOTW = rci_pkg::ROOT_W;

    logic [REMW-1:0] w_rem_sh;
    logic [REMW-1:0] w_trial;
    logic [REMW-1:0] w_diff;
    logic            w_take;
    rci_pkg::t_lane  n_lane;
    rci_pkg::t_lane  r_lane;
    rci_pkg::t_side  r_side;

    // trial subtract of (4*root + 1) from the shifted remainder
    always_comb begin
        w_rem_sh    = {i_lane.rem[REMW-3:0], i_lane.rad[RADW-1 -: 2]};
        w_trial     = {1'b0, i_lane.root, 2'b01};
        w_take      = (w_rem_sh >= w_trial);
        w_diff      = w_rem_sh - w_trial;
        n_lane.rad  = {i_lane.rad[RADW-3:0], 2'b00};
        n_lane.rem  = w_take ? w_diff : w_rem_sh;
        n_lane.root = {i_lane.root[ROOTW-2:0], w_take};
    end

    // cell register, valid cleared by reset
    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
        r_side <= i_side;
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end
    end

    assign o_lane = r_lane;
    assign o_side = r_side;

endmodule

>>> rtl/core/rci_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_front
// Projection of the center onto the ray, squared miss distance and the
// radicand r^2 - d^2, nine register stages.
// ----------------------------------------------------------------------------
module rci_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  rci_pkg::t_ray_in  i_ray,
    output rci_pkg::t_side    o_side,
    output logic [rci_pkg::RAD_W-1:0] o_rad
);

    localparam int CB    = rci_pkg::COORD_BITS;
    localparam int DB    = rci_pkg::DIR_BITS;
    localparam int DF    = rci_pkg::DIR_FRAC;
    localparam int VW    = rci_pkg::V_W;
    localparam int DPW   = rci_pkg::DOTP_W;
    localparam int DTW   = rci_pkg::DOT_W;
    localparam int TW    = rci_pkg::T_W;
    localparam int MTW   = rci_pkg::MT_W;
    localparam int PW    = rci_pkg::P_W;
    localparam int EW    = rci_pkg::E_W;
    localparam int MAGW  = rci_pkg::MAG_W;
    localparam int SQW   = rci_pkg::SQ_W;
    localparam int QW    = rci_pkg::Q_W;
    localparam int RADW  = rci_pkg::RAD_W;
    localparam int CMPW  = rci_pkg::CMP_W;
    localparam int FARW  = rci_pkg::FAR_W;
    localparam logic signed [DTW-1:0] HALF_DOT = DTW'(2 ** (DF - 1));
    localparam logic signed [MTW-1:0] HALF_MT  = MTW'(2 ** (DF - 1));

    // stage a: center minus origin, radius squared
    logic                   r_a_vld;
    logic signed [VW-1:0]   r_a_vx, r_a_vy;
    logic [RADW-1:0]        r_a_r2;
    logic signed [CB-1:0]   r_a_ox, r_a_oy, r_a_cx, r_a_cy;
    logic signed [DB-1:0]   r_a_dx, r_a_dy;
    // stage b: dot product terms
    logic                   r_b_vld;
    logic signed [DPW-1:0]  r_b_px, r_b_py;
    logic [RADW-1:0]        r_b_r2;
    logic signed [CB-1:0]   r_b_ox, r_b_oy, r_b_cx, r_b_cy;
    logic signed [DB-1:0]   r_b_dx, r_b_dy;
    // stage c: projection t
    logic signed [DTW-1:0]  w_dot;
    logic                   r_c_vld;
    logic signed [TW-1:0]   r_c_t;
    logic [RADW-1:0]        r_c_r2;
    logic signed [CB-1:0]   r_c_ox, r_c_oy, r_c_cx, r_c_cy;
    logic signed [DB-1:0]   r_c_dx, r_c_dy;
    // stage d: direction times t
    logic                   r_d_vld;
    logic signed [MTW-1:0]  r_d_mx, r_d_my;
    logic signed [TW-1:0]   r_d_t;
    logic [RADW-1:0]        r_d_r2;
    logic signed [CB-1:0]   r_d_ox, r_d_oy, r_d_cx, r_d_cy;
    logic signed [DB-1:0]   r_d_dx, r_d_dy;
    // stage e: projected point
    logic signed [MTW-1:0]  w_mx_h, w_my_h;
    logic signed [PW-2:0]   w_mx_r, w_my_r;
    logic                   r_e_vld;
    logic signed [PW-1:0]   r_e_px, r_e_py;
    logic signed [TW-1:0]   r_e_t;
    logic [RADW-1:0]        r_e_r2;
    logic signed [CB-1:0]   r_e_ox, r_e_oy, r_e_cx, r_e_cy;
    logic signed [DB-1:0]   r_e_dx, r_e_dy;
    // stage f: miss vector
    logic                   r_f_vld;
    logic signed [EW-1:0]   r_f_ex, r_f_ey;
    logic signed [TW-1:0]   r_f_t;
    logic [RADW-1:0]        r_f_r2;
    logic signed [CB-1:0]   r_f_ox, r_f_oy;
    logic signed [DB-1:0]   r_f_dx, r_f_dy;
    // stage g: magnitudes and far-line flag
    logic [EW-1:0]          w_ax, w_ay;
    logic                   r_g_vld;
    logic                   r_g_far;
    logic [MAGW-1:0]        r_g_mx, r_g_my;
    logic signed [TW-1:0]   r_g_t;
    logic [RADW-1:0]        r_g_r2;
    logic signed [CB-1:0]   r_g_ox, r_g_oy;
    logic signed [DB-1:0]   r_g_dx, r_g_dy;
    // stage h: squares
    logic                   r_h_vld;
    logic                   r_h_far;
    logic [SQW-1:0]         r_h_sx, r_h_sy;
    logic signed [TW-1:0]   r_h_t;
    logic [RADW-1:0]        r_h_r2;
    logic signed [CB-1:0]   r_h_ox, r_h_oy;
    logic signed [DB-1:0]   r_h_dx, r_h_dy;
    // stage i: hit test and radicand
    logic [QW-1:0]          w_q;
    logic                   w_hit;
    rci_pkg::t_side         r_i_side;
    logic [RADW-1:0]        r_i_rad;

    // stage a
    always_ff @(posedge i_clk) begin
        r_a_vld <= i_vld;
        r_a_vx  <= VW'(i_ray.center_x) - VW'(i_ray.origin_x);
        r_a_vy  <= VW'(i_ray.center_y) - VW'(i_ray.origin_y);
        r_a_r2  <= RADW'(i_ray.radius) * RADW'(i_ray.radius);
        r_a_ox  <= i_ray.origin_x;
        r_a_oy  <= i_ray.origin_y;
        r_a_cx  <= i_ray.center_x;
        r_a_cy  <= i_ray.center_y;
        r_a_dx  <= i_ray.dir_x;
        r_a_dy  <= i_ray.dir_y;
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end
    end

    // stage b
    always_ff @(posedge i_clk) begin
        r_b_vld <= r_a_vld;
        r_b_px  <= DPW'(r_a_vx) * DPW'(r_a_dx);
        r_b_py  <= DPW'(r_a_vy) * DPW'(r_a_dy);
        r_b_r2  <= r_a_r2;
        r_b_ox  <= r_a_ox;
        r_b_oy  <= r_a_oy;
        r_b_cx  <= r_a_cx;
        r_b_cy  <= r_a_cy;
        r_b_dx  <= r_a_dx;
        r_b_dy  <= r_a_dy;
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end
    end

    // stage c: round half up, then floor by 2^14
    assign w_dot = DTW'(r_b_px) + DTW'(r_b_py) + HALF_DOT;

    always_ff @(posedge i_clk) begin
        r_c_vld <= r_b_vld;
        r_c_t   <= w_dot[DTW-1:DF];
        r_c_r2  <= r_b_r2;
        r_c_ox  <= r_b_ox;
        r_c_oy  <= r_b_oy;
        r_c_cx  <= r_b_cx;
        r_c_cy  <= r_b_cy;
        r_c_dx  <= r_b_dx;
        r_c_dy  <= r_b_dy;
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end
    end

    // stage d
    always_ff @(posedge i_clk) begin
        r_d_vld <= r_c_vld;
        r_d_mx  <= MTW'(r_c_dx) * MTW'(r_c_t);
        r_d_my  <= MTW'(r_c_dy) * MTW'(r_c_t);
        r_d_t   <= r_c_t;
        r_d_r2  <= r_c_r2;
        r_d_ox  <= r_c_ox;
        r_d_oy  <= r_c_oy;
        r_d_cx  <= r_c_cx;
        r_d_cy  <= r_c_cy;
        r_d_dx  <= r_c_dx;
        r_d_dy  <= r_c_dy;
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end
    end

    // stage e: rounded offset plus origin
    assign w_mx_h = r_d_mx + HALF_MT;
    assign w_my_h = r_d_my + HALF_MT;
    assign w_mx_r = w_mx_h[MTW-1:DF];
    assign w_my_r = w_my_h[MTW-1:DF];

    always_ff @(posedge i_clk) begin
        r_e_vld <= r_d_vld;
        r_e_px  <= PW'(w_mx_r) + PW'(r_d_ox);
        r_e_py  <= PW'(w_my_r) + PW'(r_d_oy);
        r_e_t   <= r_d_t;
        r_e_r2  <= r_d_r2;
        r_e_ox  <= r_d_ox;
        r_e_oy  <= r_d_oy;
        r_e_cx  <= r_d_cx;
        r_e_cy  <= r_d_cy;
        r_e_dx  <= r_d_dx;
        r_e_dy  <= r_d_dy;
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end
    end

    // stage f
    always_ff @(posedge i_clk) begin
        r_f_vld <= r_e_vld;
        r_f_ex  <= EW'(r_e_cx) - EW'(r_e_px);
        r_f_ey  <= EW'(r_e_cy) - EW'(r_e_py);
        r_f_t   <= r_e_t;
        r_f_r2  <= r_e_r2;
        r_f_ox  <= r_e_ox;
        r_f_oy  <= r_e_oy;
        r_f_dx  <= r_e_dx;
        r_f_dy  <= r_e_dy;
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end
    end

    // stage g: a miss of 2^31 or more in either axis can never hit
    assign w_ax = r_f_ex[EW-1] ? -r_f_ex : r_f_ex;
    assign w_ay = r_f_ey[EW-1] ? -r_f_ey : r_f_ey;

    always_ff @(posedge i_clk) begin
        r_g_vld <= r_f_vld;
        r_g_far <= ({{(FARW-EW){1'b0}}, w_ax} >= rci_pkg::FAR_LIMIT)
                || ({{(FARW-EW){1'b0}}, w_ay} >= rci_pkg::FAR_LIMIT);
        r_g_mx  <= w_ax[MAGW-1:0];
        r_g_my  <= w_ay[MAGW-1:0];
        r_g_t   <= r_f_t;
        r_g_r2  <= r_f_r2;
        r_g_ox  <= r_f_ox;
        r_g_oy  <= r_f_oy;
        r_g_dx  <= r_f_dx;
        r_g_dy  <= r_f_dy;
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end
    end

    // stage h
    always_ff @(posedge i_clk) begin
        r_h_vld <= r_g_vld;
        r_h_far <= r_g_far;
        r_h_sx  <= SQW'(r_g_mx) * SQW'(r_g_mx);
        r_h_sy  <= SQW'(r_g_my) * SQW'(r_g_my);
        r_h_t   <= r_g_t;
        r_h_r2  <= r_g_r2;
        r_h_ox  <= r_g_ox;
        r_h_oy  <= r_g_oy;
        r_h_dx  <= r_g_dx;
        r_h_dy  <= r_g_dy;
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end
    end

    // stage i: strict test r^2 > d^2
    assign w_q   = QW'(r_h_sx) + QW'(r_h_sy);
    assign w_hit = !r_h_far && (CMPW'(w_q) < CMPW'(r_h_r2));

    always_ff @(posedge i_clk) begin
        r_i_side.vld <= r_h_vld;
        r_i_side.hit <= w_hit;
        r_i_side.t   <= r_h_t;
        r_i_side.ox  <= r_h_ox;
        r_i_side.oy  <= r_h_oy;
        r_i_side.dx  <= r_h_dx;
        r_i_side.dy  <= r_h_dy;
        r_i_rad      <= r_h_r2 - w_q[RADW-1:0];
        if (!i_rst_n) begin
            r_i_side.vld <= 1'b0;
        end
    end

    assign o_side = r_i_side;
    assign o_rad  = r_i_rad;

endmodule

>>> rtl/core/rci_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_back
// Entry distance t - x, entry point origin + dir*t1, saturation and the
// result register, four register stages.
// ----------------------------------------------------------------------------
module rci_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rci_pkg::t_side             i_side,
    input  logic [rci_pkg::ROOT_W-1:0] i_root,
    output logic                       o_done,
    output rci_pkg::t_ray_out          o_result
);

    localparam int CB    = rci_pkg::COORD_BITS;
    localparam int DB    = rci_pkg::DIR_BITS;
    localparam int DF    = rci_pkg::DIR_FRAC;
    localparam int ROOTW = rci_pkg::ROOT_W;
    localparam int T1W   = rci_pkg::T1_W;
    localparam int M1W   = rci_pkg::M1_W;
    localparam int P1W   = rci_pkg::P1_W;
    localparam logic signed [M1W-1:0] HALF_M1 = M1W'(2 ** (DF - 1));

    // clamp to the signed coordinate range
    function automatic logic signed [CB-1:0] sat_coord(input logic signed [P1W-1:0] v);
        logic [P1W-CB:0] upper;
        logic [CB-1:0]   res;
        upper = v[P1W-1:CB-1];
        if (upper == '0 || upper == '1) begin
            res = v[CB-1:0];
        end else if (v[P1W-1]) begin
            res = {1'b1, {(CB-1){1'b0}}};
        end else begin
            res = {1'b0, {(CB-1){1'b1}}};
        end
        return res;
    endfunction

    // stage j
    logic                  r_j_vld, r_j_hit;
    logic signed [T1W-1:0] r_j_t1;
    logic signed [CB-1:0]  r_j_ox, r_j_oy;
    logic signed [DB-1:0]  r_j_dx, r_j_dy;
    // stage k
    logic                  r_k_vld, r_k_hit;
    logic signed [T1W-1:0] r_k_t1;
    logic signed [M1W-1:0] r_k_mx, r_k_my;
    logic signed [CB-1:0]  r_k_ox, r_k_oy;
    // stage l
    logic signed [M1W-1:0]    w_mx_h, w_my_h;
    logic signed [M1W-DF-1:0] w_mx_r, w_my_r;
    logic                     r_l_vld, r_l_hit;
    logic signed [T1W-1:0]    r_l_t1;
    logic signed [P1W-1:0]    r_l_px, r_l_py;
    // stage m
    logic                  r_done;
    rci_pkg::t_ray_out     r_out;

    // stage j: entry distance
    always_ff @(posedge i_clk) begin
        r_j_vld <= i_side.vld;
        r_j_hit <= i_side.hit;
        r_j_t1  <= T1W'(i_side.t) - {{(T1W-ROOTW){1'b0}}, i_root};
        r_j_ox  <= i_side.ox;
        r_j_oy  <= i_side.oy;
        r_j_dx  <= i_side.dx;
        r_j_dy  <= i_side.dy;
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
        end
    end

    // stage k
    always_ff @(posedge i_clk) begin
        r_k_vld <= r_j_vld;
        r_k_hit <= r_j_hit;
        r_k_t1  <= r_j_t1;
        r_k_mx  <= M1W'(r_j_dx) * M1W'(r_j_t1);
        r_k_my  <= M1W'(r_j_dy) * M1W'(r_j_t1);
        r_k_ox  <= r_j_ox;
        r_k_oy  <= r_j_oy;
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end
    end

    // stage l: rounded offset plus origin
    assign w_mx_h = r_k_mx + HALF_M1;
    assign w_my_h = r_k_my + HALF_M1;
    assign w_mx_r = w_mx_h[M1W-1:DF];
    assign w_my_r = w_my_h[M1W-1:DF];

    always_ff @(posedge i_clk) begin
        r_l_vld <= r_k_vld;
        r_l_hit <= r_k_hit;
        r_l_t1  <= r_k_t1;
        r_l_px  <= P1W'(w_mx_r) + P1W'(r_k_ox);
        r_l_py  <= P1W'(w_my_r) + P1W'(r_k_oy);
        if (!i_rst_n) begin
            r_l_vld <= 1'b0;
        end
    end

    // stage m: result register, fields zero on a miss
    always_ff @(posedge i_clk) begin
        r_done    <= r_l_vld;
        r_out.hit <= r_l_hit;
        if (r_l_hit) begin
            r_out.entry_distance <= sat_coord(P1W'(r_l_t1));
            r_out.point_x        <= sat_coord(r_l_px);
            r_out.point_y        <= sat_coord(r_l_py);
        end else begin
            r_out.entry_distance <= '0;
            r_out.point_x        <= '0;
            r_out.point_y        <= '0;
        end
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

>>> rtl/core/ray_circle_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_circle_intersect
// Entry point of a 2D ray into a circle, fully pipelined, with a chain of
// square root cells for the half chord.
// ----------------------------------------------------------------------------
//  channel   signals                  direction  transaction when
//  request   start, busy, i_ray       in         start high and busy low
//  result    o_done, o_result         out        o_done high, one cycle
//
//  One request per cycle; busy stays low, the pipeline never backs up.
//  The path runs through 9 projection and distance stages, one square
//  root cell per root bit (COORD_BITS - 1), and 4 entry point and output
//  stages.
//  Synchronous active-low reset clears every stage valid; data in flight
//  is dropped. The receiver cannot stall: each result shows for one cycle.
// ----------------------------------------------------------------------------
module ray_circle_intersect (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rci_pkg::t_ray_in  i_ray,
    output logic              o_done,
    output rci_pkg::t_ray_out o_result
);

    localparam int ROOTW    = rci_pkg::ROOT_W;
    localparam int RADW     = rci_pkg::RAD_W;
    localparam int BACK_LAT = 4;

    logic            w_accept;
    logic [RADW-1:0] w_rad;
    rci_pkg::t_side  w_side [0:ROOTW];
    rci_pkg::t_lane  w_lane [0:ROOTW];

    // a new transaction is taken every cycle
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // projection, distance and radicand
    rci_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_ray   (i_ray),
        .o_side  (w_side[0]),
        .o_rad   (w_rad)
    );

    // square root chain input
    always_comb begin
        w_lane[0].rad  = w_rad;
        w_lane[0].rem  = '0;
        w_lane[0].root = '0;
    end

    // one cell per root bit, most significant first
    for (genvar g = 0; g < ROOTW; g++) begin : g_cell
        rci_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (w_side[g]),
            .i_lane  (w_lane[g]),
            .o_side  (w_side[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    // entry distance, entry point, output register
    rci_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_side   (w_side[ROOTW]),
        .i_root   (w_lane[ROOTW].root),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // every transaction entering the chain leaves it, passing one register per cell
    a_chain_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_side[0].vld |-> ##ROOTW w_side[ROOTW].vld)
        else $error("square root chain lost a transaction");

    // a result strobe traces back to the chain output
    a_back_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_side[ROOTW].vld, BACK_LAT))
        else $error("result strobe without a matching chain transaction");

    // the hit flag survives the back stages
    a_hit_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.hit == $past(w_side[ROOTW].hit, BACK_LAT)))
        else $error("hit flag changed between chain and result");

    // a miss carries zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.hit) |->
            (o_result.entry_distance == '0 && o_result.point_x == '0
             && o_result.point_y == '0))
        else $error("miss result with nonzero fields");

endmodule
